### src/text_console_char_writer_top_macros.svh
// assertion macros for the console writer top level
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH

// same-cycle implication
`define TCCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/tccw_pkg.sv
// shared constants, codes and controller/datapath interface types for the console writer
package tccw_pkg;

	localparam int DEF_COLS = 80;
	localparam int DEF_ROWS = 25;
	localparam int TAB_STOP = 4;
	localparam int PAD_W    = 3;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [7:0] RESET_COLOR = 8'h07;
	localparam logic       RESET_OE    = 1'b1;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ENABLE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_COLOR   = 8'd1;

	typedef enum logic [1:0] {
		ACT_PUT        = 2'd0,
		ACT_CLEAR      = 2'd1,
		ACT_SET_CURSOR = 2'd2,
		ACT_READ_CELL  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		RES_NONE      = 2'd0,
		RES_ECHO_IN   = 2'd1,
		RES_ECHO_BYTE = 2'd2,
		RES_CELL      = 2'd3
	} res_kind_t;

	typedef struct packed {
		logic      accept_put;
		logic      set_cursor;
		logic      put_step;
		logic      pad_dec;
		logic      sweep_copy;
		logic      sweep_clear;
		logic      home_cursor;
		logic      emit;
		res_kind_t kind;
		logic      last;
	} dp_cmd_t;

	typedef struct packed {
		logic is_tab;
		logic oe;
		logic scroll_need;
		logic pad_last;
		logic sweep_done;
	} dp_stat_t;

endpackage

### src/tccw_ctrl.sv
// controller state machine for the console writer
module tccw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         action,
	input  tccw_pkg::dp_stat_t stat,
	output logic               busy,
	output tccw_pkg::dp_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_PUT    = 6'b000100,
		ST_SCROLL = 6'b001000,
		ST_CLEAR  = 6'b010000,
		ST_READ   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				// store blanking pass after reset
				if (stat.sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					unique case (tccw_pkg::action_t'(action))
						tccw_pkg::ACT_PUT: begin
							if (!stat.oe) begin
								cmd.emit = 1'b1;
								cmd.kind = tccw_pkg::RES_NONE;
								cmd.last = 1'b1;
							end else begin
								cmd.accept_put = 1'b1;
								state_d        = ST_PUT;
								if (stat.is_tab) begin
									// the tab itself is echoed before the padding
									cmd.emit = 1'b1;
									cmd.kind = tccw_pkg::RES_ECHO_IN;
									cmd.last = 1'b0;
								end
							end
						end
						tccw_pkg::ACT_CLEAR: begin
							cmd.sweep_clear = 1'b1;
							cmd.home_cursor = 1'b1;
							state_d         = ST_CLEAR;
						end
						tccw_pkg::ACT_SET_CURSOR: begin
							cmd.set_cursor = 1'b1;
							cmd.emit       = 1'b1;
							cmd.kind       = tccw_pkg::RES_NONE;
							cmd.last       = 1'b1;
						end
						tccw_pkg::ACT_READ_CELL: begin
							state_d = ST_READ;
						end
					endcase
				end
			end
			ST_PUT: begin
				cmd.put_step = 1'b1;
				if (stat.scroll_need) begin
					cmd.sweep_copy = 1'b1;
					state_d        = ST_SCROLL;
				end else begin
					cmd.emit    = 1'b1;
					cmd.kind    = tccw_pkg::RES_ECHO_BYTE;
					cmd.last    = stat.pad_last;
					cmd.pad_dec = 1'b1;
					if (stat.pad_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SCROLL: begin
				if (stat.sweep_done) begin
					cmd.emit    = 1'b1;
					cmd.kind    = tccw_pkg::RES_ECHO_BYTE;
					cmd.last    = stat.pad_last;
					cmd.pad_dec = 1'b1;
					state_d     = stat.pad_last ? ST_IDLE : ST_PUT;
				end
			end
			ST_CLEAR: begin
				if (stat.sweep_done) begin
					cmd.emit = 1'b1;
					cmd.kind = tccw_pkg::RES_NONE;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.emit = 1'b1;
				cmd.kind = tccw_pkg::RES_CELL;
				cmd.last = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### src/tccw_dp.sv
// datapath for the console writer: cursor, cell store, sweep engine, config and result registers
module tccw_dp #(
	parameter int COLS = tccw_pkg::DEF_COLS,
	parameter int ROWS = tccw_pkg::DEF_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [7:0]                      char_code,
	input  logic [6:0]                      col,
	input  logic [4:0]                      row,
	input  logic                            cfg_valid,
	input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  tccw_pkg::dp_cmd_t               cmd,
	output tccw_pkg::dp_stat_t              stat,
	output logic                            result_valid,
	output logic                            echo_valid,
	output logic [7:0]                      echo_byte,
	output logic [6:0]                      cursor_col,
	output logic [4:0]                      cursor_row,
	output logic [10:0]                     cursor_pos,
	output logic [7:0]                      cell_char,
	output logic [7:0]                      cell_color,
	output logic                            last
);

	localparam int CELLS    = COLS * ROWS;
	localparam int COL_W    = $clog2(COLS);
	localparam int ROW_W    = $clog2(ROWS);
	localparam int CELL_W   = $clog2(CELLS);
	localparam int COPY_END = CELLS - COLS;
	localparam int PAD_W    = tccw_pkg::PAD_W;

	// cursor and current byte
	logic [COL_W-1:0]  col_q, nxt_col, in_col_sat;
	logic [ROW_W-1:0]  row_q, nxt_row, in_row_sat;
	logic [COL_W:0]    col_inc;
	logic [ROW_W:0]    row_inc;
	logic              row_adv, scroll_need, is_lf, is_cr, put_wr;
	logic [7:0]        byte_q;
	logic [PAD_W-1:0]  pad_q, pad_init;
	logic [CELL_W-1:0] cur_addr, in_addr;

	// config
	logic       oe_q;
	logic [7:0] blank_color_q;

	// sweep engine
	logic              sw_run_q, sw_blank_q;
	logic [CELL_W-1:0] sw_cnt_q;
	logic [7:0]        sw_color_q;
	logic [CELL_W:0]   sw_src;
	logic              sw_act_s1, sw_copy_s1, sw_last_s1;
	logic [CELL_W-1:0] sw_addr_s1;

	// cell store
	logic [7:0]        char_mem  [CELLS];
	logic [7:0]        color_mem [CELLS];
	logic [CELL_W-1:0] rd_addr, wr_addr;
	logic [7:0]        wr_char, wr_color, rd_char_q, rd_color_q;
	logic              char_we, color_we;

	// result
	logic       res_valid_q, res_echo_valid_q, res_last_q;
	logic [7:0] res_echo_q, res_char_q, res_color_q;

	assign in_col_sat = (int'(col) > COLS - 1) ? COL_W'(COLS - 1) : COL_W'(col);
	assign in_row_sat = (int'(row) > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(row);

	assign cur_addr = CELL_W'(row_q) * CELL_W'(COLS) + CELL_W'(col_q);
	assign in_addr  = CELL_W'(in_row_sat) * CELL_W'(COLS) + CELL_W'(in_col_sat);

	assign pad_init = PAD_W'(tccw_pkg::TAB_STOP - (int'(col_q) % tccw_pkg::TAB_STOP));

	assign is_lf   = (byte_q == tccw_pkg::CH_LF);
	assign is_cr   = (byte_q == tccw_pkg::CH_CR);
	assign col_inc = {1'b0, col_q} + (COL_W + 1)'(1);
	assign row_inc = {1'b0, row_q} + (ROW_W + 1)'(1);

	always_comb begin
		nxt_col = col_q;
		row_adv = 1'b0;
		if (is_lf) begin
			nxt_col = '0;
			row_adv = 1'b1;
		end else if (is_cr) begin
			nxt_col = '0;
		end else if (col_inc == (COL_W + 1)'(COLS)) begin
			nxt_col = '0;
			row_adv = 1'b1;
		end else begin
			nxt_col = col_inc[COL_W-1:0];
		end
	end

	assign scroll_need = row_adv && (row_inc == (ROW_W + 1)'(ROWS));
	assign nxt_row     = !row_adv    ? row_q :
	                     scroll_need ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0];
	assign put_wr      = cmd.put_step && !is_lf && !is_cr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.set_cursor) begin
			col_q <= in_col_sat;
			row_q <= in_row_sat;
		end else if (cmd.home_cursor) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.put_step) begin
			col_q <= nxt_col;
			row_q <= nxt_row;
		end
	end

	// tab becomes a run of spaces; other bytes run once
	always_ff @(posedge clk) begin
		if (cmd.accept_put) begin
			byte_q <= (char_code == tccw_pkg::CH_TAB) ? tccw_pkg::CH_SPACE : char_code;
			pad_q  <= (char_code == tccw_pkg::CH_TAB) ? pad_init : PAD_W'(1);
		end else if (cmd.pad_dec) begin
			pad_q <= pad_q - PAD_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oe_q          <= tccw_pkg::RESET_OE;
			blank_color_q <= tccw_pkg::RESET_COLOR;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tccw_pkg::REG_OUTPUT_ENABLE: oe_q          <= cfg_data[0];
				tccw_pkg::REG_BLANK_COLOR:   blank_color_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sweep: reset starts a blanking pass with the reset color
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_run_q   <= 1'b1;
			sw_blank_q <= 1'b1;
			sw_cnt_q   <= '0;
			sw_color_q <= tccw_pkg::RESET_COLOR;
			sw_act_s1  <= 1'b0;
		end else begin
			sw_act_s1 <= sw_run_q;
			if (cmd.sweep_copy || cmd.sweep_clear) begin
				sw_run_q   <= 1'b1;
				sw_blank_q <= cmd.sweep_clear;
				sw_cnt_q   <= '0;
				sw_color_q <= blank_color_q;
			end else if (sw_run_q) begin
				sw_cnt_q <= sw_cnt_q + CELL_W'(1);
				if (sw_cnt_q == CELL_W'(CELLS - 1)) begin
					sw_run_q <= 1'b0;
				end
			end
		end
	end

	// copy writes in the cycle after its read; the bottom row gets blanks
	always_ff @(posedge clk) begin
		sw_copy_s1 <= !sw_blank_q && (int'(sw_cnt_q) < COPY_END);
		sw_last_s1 <= (sw_cnt_q == CELL_W'(CELLS - 1));
		sw_addr_s1 <= sw_cnt_q;
	end

	assign sw_src  = {1'b0, sw_cnt_q} + (CELL_W + 1)'(COLS);
	assign rd_addr = sw_run_q ? sw_src[CELL_W-1:0] : in_addr;

	assign wr_addr  = sw_act_s1 ? sw_addr_s1 : cur_addr;
	assign wr_char  = !sw_act_s1 ? byte_q :
	                  sw_copy_s1 ? rd_char_q : tccw_pkg::CH_SPACE;
	assign wr_color = sw_copy_s1 ? rd_color_q : sw_color_q;
	assign char_we  = sw_act_s1 || put_wr;
	assign color_we = sw_act_s1;

	always_ff @(posedge clk) begin
		if (char_we) begin
			char_mem[wr_addr] <= wr_char;
		end
		if (color_we) begin
			color_mem[wr_addr] <= wr_color;
		end
		rd_char_q  <= char_mem[rd_addr];
		rd_color_q <= color_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_last_q <= cmd.last;
			unique case (cmd.kind)
				tccw_pkg::RES_NONE: begin
					res_echo_valid_q <= 1'b0;
					res_echo_q       <= '0;
					res_char_q       <= '0;
					res_color_q      <= '0;
				end
				tccw_pkg::RES_ECHO_IN: begin
					res_echo_valid_q <= 1'b1;
					res_echo_q       <= char_code;
					res_char_q       <= '0;
					res_color_q      <= '0;
				end
				tccw_pkg::RES_ECHO_BYTE: begin
					res_echo_valid_q <= 1'b1;
					res_echo_q       <= byte_q;
					res_char_q       <= '0;
					res_color_q      <= '0;
				end
				tccw_pkg::RES_CELL: begin
					res_echo_valid_q <= 1'b0;
					res_echo_q       <= '0;
					res_char_q       <= rd_char_q;
					res_color_q      <= rd_color_q;
				end
			endcase
		end
	end

	assign stat.is_tab      = (char_code == tccw_pkg::CH_TAB);
	assign stat.oe          = oe_q;
	assign stat.scroll_need = scroll_need;
	assign stat.pad_last    = (pad_q == PAD_W'(1));
	assign stat.sweep_done  = sw_act_s1 && sw_last_s1;

	assign result_valid = res_valid_q;
	assign echo_valid   = res_echo_valid_q;
	assign echo_byte    = res_echo_q;
	assign cell_char    = res_char_q;
	assign cell_color   = res_color_q;
	assign last         = res_last_q;
	// cursor fields follow the cursor registers combinationally
	assign cursor_col   = 7'(col_q);
	assign cursor_row   = 5'(row_q);
	assign cursor_pos   = 11'(cur_addr);

endmodule

### src/text_console_char_writer_top.sv
// plain byte: echo from put or scroll state; set cursor: from idle; read cell: from read state
// tab: tab echo then 4 - (col mod 4) space results, one per cycle unless a scroll holds them
// scroll and clear sweep all COLS*ROWS cells through the store's separate read and write ports
// each result holds the ports for one cycle with result_valid, the receiver cannot stall
// reset: cursor home, output enabled, blank color 7; a pass with the reset color then blanks
// the store with busy high, config writes are taken meanwhile
`include "text_console_char_writer_top_macros.svh"

module text_console_char_writer_top #(
	parameter int COLS = tccw_pkg::DEF_COLS,
	parameter int ROWS = tccw_pkg::DEF_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      action,
	input  logic [7:0]                      char_code,
	input  logic [6:0]                      col,
	input  logic [4:0]                      row,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            result_valid,
	output logic                            echo_valid,
	output logic [7:0]                      echo_byte,
	output logic [6:0]                      cursor_col,
	output logic [4:0]                      cursor_row,
	output logic [10:0]                     cursor_pos,
	output logic [7:0]                      cell_char,
	output logic [7:0]                      cell_color,
	output logic                            last
);

	tccw_pkg::dp_cmd_t  cmd;
	tccw_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	tccw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	tccw_dp #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_code    (char_code),
		.col          (col),
		.row          (row),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.echo_valid   (echo_valid),
		.echo_byte    (echo_byte),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.cursor_pos   (cursor_pos),
		.cell_char    (cell_char),
		.cell_color   (cell_color),
		.last         (last)
	);

	// a final result leaves the controller idle, any other result keeps it busy
	`TCCW_ASSERT_NOW(a_last_vs_busy, result_valid, last != busy, "last result while busy or early result while idle")
	`TCCW_ASSERT_NEXT(a_set_cursor_res, start && !busy && action == tccw_pkg::ACT_SET_CURSOR, result_valid && last, "set cursor request gave no immediate result")
	`TCCW_ASSERT_NEXT(a_read_latency, start && !busy && action == tccw_pkg::ACT_READ_CELL, !result_valid ##1 (result_valid && last), "read cell result not two cycles after request")

endmodule

### verif/testbench.sv
// self-checking testbench for the text console character writer
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS      = tccw_pkg::DEF_COLS;
	localparam int ROWS      = tccw_pkg::DEF_ROWS;
	localparam int CELLS     = COLS * ROWS;
	localparam int MAX_CYCLE = 2000000;
	localparam int TAIL      = 40;

	typedef struct packed {
		tccw_pkg::action_t act;
		logic [7:0]        ch;
		logic [6:0]        c;
		logic [4:0]        r;
	} console_req_t;

	typedef struct packed {
		logic        echo_valid;
		logic [7:0]  echo_byte;
		logic [6:0]  ccol;
		logic [4:0]  crow;
		logic [10:0] cpos;
		logic [7:0]  cchar;
		logic [7:0]  ccolor;
		logic        is_last;
	} console_out_t;

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic [1:0]                      action;
	logic [7:0]                      char_code;
	logic [6:0]                      col;
	logic [4:0]                      row;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            result_valid;
	logic                            echo_valid;
	logic [7:0]                      echo_byte;
	logic [6:0]                      cursor_col;
	logic [4:0]                      cursor_row;
	logic [10:0]                     cursor_pos;
	logic [7:0]                      cell_char;
	logic [7:0]                      cell_color;
	logic                            last;

	text_console_char_writer_top #(.COLS(COLS), .ROWS(ROWS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .char_code(char_code), .col(col), .row(row),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .echo_valid(echo_valid),
		.echo_byte(echo_byte), .cursor_col(cursor_col), .cursor_row(cursor_row),
		.cursor_pos(cursor_pos), .cell_char(cell_char), .cell_color(cell_color),
		.last(last)
	);

	// predicted screen state
	logic [15:0] screen [CELLS];
	int          cur_col;
	int          cur_row;
	logic        out_en;
	logic [7:0]  blank_attr;

	console_req_t req_q[$];
	console_out_t console_out_q[$];
	int           pushed_count;
	int           accepted_count;
	int           errors;
	int           cycles;
	int           burst_left;
	int           gap_left;
	int           last_c;
	int           last_r;
	logic         start_taken;

	console_out_t want;
	console_out_t got;
	console_req_t next_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= MAX_CYCLE) begin
			$display("FAIL text_console_char_writer_top");
			$finish;
		end
	end

	function automatic logic [15:0] blank_cell();
		return {blank_attr, tccw_pkg::CH_SPACE};
	endfunction

	task automatic scroll_screen();
		for (int i = 0; i < COLS * (ROWS - 1); i++)
			screen[i] = screen[i + COLS];
		for (int i = 0; i < COLS; i++)
			screen[(ROWS - 1) * COLS + i] = blank_cell();
		cur_row = ROWS - 1;
	endtask

	task automatic console_byte(logic [7:0] b);
		if (b == tccw_pkg::CH_LF) begin
			cur_col = 0;
			cur_row++;
		end else if (b == tccw_pkg::CH_CR) begin
			cur_col = 0;
		end else begin
			screen[cur_row * COLS + cur_col][7:0] = b;
			cur_col++;
		end
		if (cur_col >= COLS) begin
			cur_row++;
			cur_col = 0;
		end
		if (cur_row >= ROWS)
			scroll_screen();
	endtask

	task automatic push_output(logic ev, logic [7:0] eb, logic [7:0] cc, logic [7:0] ccl);
		console_out_t o;
		int           lin;
		lin = cur_row * COLS + cur_col;
		o.echo_valid = ev;
		o.echo_byte  = eb;
		o.ccol       = cur_col[6:0];
		o.crow       = cur_row[4:0];
		o.cpos       = lin[10:0];
		o.cchar      = cc;
		o.ccolor     = ccl;
		o.is_last    = 1'b0;
		console_out_q.push_back(o);
	endtask

	// expected outputs of one accepted request
	task automatic run_console_request(console_req_t q);
		int          c;
		int          r;
		int          pad;
		logic [15:0] rd_cell;
		c = (q.c > COLS - 1) ? COLS - 1 : q.c;
		r = (q.r > ROWS - 1) ? ROWS - 1 : q.r;
		case (q.act)
			tccw_pkg::ACT_PUT: begin
				if (!out_en) begin
					push_output(1'b0, 8'h00, 8'h00, 8'h00);
				end else if (q.ch == tccw_pkg::CH_TAB) begin
					pad = tccw_pkg::TAB_STOP - (cur_col % tccw_pkg::TAB_STOP);
					push_output(1'b1, q.ch, 8'h00, 8'h00);
					for (int i = 0; i < pad; i++) begin
						console_byte(tccw_pkg::CH_SPACE);
						push_output(1'b1, tccw_pkg::CH_SPACE, 8'h00, 8'h00);
					end
				end else begin
					console_byte(q.ch);
					push_output(1'b1, q.ch, 8'h00, 8'h00);
				end
			end
			tccw_pkg::ACT_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen[i] = blank_cell();
				cur_col = 0;
				cur_row = 0;
				push_output(1'b0, 8'h00, 8'h00, 8'h00);
			end
			tccw_pkg::ACT_SET_CURSOR: begin
				cur_col = c;
				cur_row = r;
				push_output(1'b0, 8'h00, 8'h00, 8'h00);
			end
			default: begin
				rd_cell = screen[r * COLS + c];
				push_output(1'b0, 8'h00, rd_cell[7:0], rd_cell[15:8]);
			end
		endcase
		console_out_q[console_out_q.size() - 1].is_last = 1'b1;
	endtask

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// monitor: results first, then config writes and requests taken at this edge
	always @(posedge clk) begin
		start_taken = 1'b0;
		if (arst_n) begin
			if (result_valid) begin
				got = '{echo_valid, echo_byte, cursor_col, cursor_row, cursor_pos,
					cell_char, cell_color, last};
				if (console_out_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, got);
					errors++;
				end else begin
					want = console_out_q.pop_front();
					check_field("echo_valid", want.echo_valid, got.echo_valid);
					check_field("echo_byte", want.echo_byte, got.echo_byte);
					check_field("cursor_col", want.ccol, got.ccol);
					check_field("cursor_row", want.crow, got.crow);
					check_field("cursor_pos", want.cpos, got.cpos);
					check_field("cell_char", want.cchar, got.cchar);
					check_field("cell_color", want.ccolor, got.ccolor);
					check_field("last", want.is_last, got.is_last);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tccw_pkg::REG_OUTPUT_ENABLE)
					out_en = cfg_data[0];
				else if (cfg_index == tccw_pkg::REG_BLANK_COLOR)
					blank_attr = cfg_data;
			end
			if (start && !busy) begin
				start_taken = 1'b1;
				run_console_request('{tccw_pkg::action_t'(action), char_code, col, row});
				accepted_count++;
			end
		end
	end

	// driver: bursts of requests with random gaps
	always @(negedge clk) begin
		if (!start || start_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (req_q.size() > 0) begin
				next_req = req_q.pop_front();
				start     <= 1'b1;
				action    <= next_req.act;
				char_code <= next_req.ch;
				col       <= next_req.c;
				row       <= next_req.r;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 10);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 :
						(($urandom_range(0, 7) == 0) ? 25 : $urandom_range(1, 6));
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic queue_request(tccw_pkg::action_t a, logic [7:0] ch, logic [6:0] c,
		logic [4:0] r);
		req_q.push_back('{a, ch, c, r});
		pushed_count++;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (!(accepted_count == pushed_count && console_out_q.size() == 0 && !busy));
	endtask

	task automatic write_register(logic [tccw_pkg::CFG_IDX_W-1:0] idx,
		logic [tccw_pkg::CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_random_request();
		int          p;
		logic [7:0]  ch;
		logic [6:0]  c;
		logic [4:0]  r;
		p  = $urandom_range(0, 99);
		ch = 8'($urandom_range(0, 255));
		c  = 7'($urandom_range(0, 127));
		r  = 5'($urandom_range(0, 31));
		if (p < 60) begin
			p = $urandom_range(0, 99);
			if (p < 10)
				ch = tccw_pkg::CH_LF;
			else if (p < 15)
				ch = tccw_pkg::CH_CR;
			else if (p < 25)
				ch = tccw_pkg::CH_TAB;
			else if (p < 75)
				ch = 8'($urandom_range(8'h21, 8'h7E));
			queue_request(tccw_pkg::ACT_PUT, ch, c, r);
		end else if (p < 75) begin
			// often near the right edge or bottom so wraps and scrolls happen
			if ($urandom_range(0, 1))
				c = 7'($urandom_range(COLS - 6, COLS - 1));
			if ($urandom_range(0, 9) < 4)
				r = 5'($urandom_range(ROWS - 3, 31));
			last_c = (c > COLS - 1) ? COLS - 1 : c;
			last_r = (r > ROWS - 1) ? ROWS - 1 : r;
			queue_request(tccw_pkg::ACT_SET_CURSOR, ch, c, r);
		end else if (p < 96) begin
			if ($urandom_range(0, 1)) begin
				c = 7'(last_c + $urandom_range(0, 7));
				r = 5'(last_r);
			end
			queue_request(tccw_pkg::ACT_READ_CELL, ch, c, r);
		end else begin
			queue_request(tccw_pkg::ACT_CLEAR, ch, c, r);
		end
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++)
			screen[i] = {tccw_pkg::RESET_COLOR, tccw_pkg::CH_SPACE};
		cur_col        = 0;
		cur_row        = 0;
		out_en         = tccw_pkg::RESET_OE;
		blank_attr     = tccw_pkg::RESET_COLOR;
		pushed_count   = 0;
		accepted_count = 0;
		errors         = 0;
		cycles         = 0;
		burst_left     = 1;
		gap_left       = 0;
		last_c         = 0;
		last_r         = ROWS - 1;
		start_taken    = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		action         = tccw_pkg::ACT_PUT;
		char_code      = 8'h00;
		col            = 7'd0;
		row            = 5'd0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		wait_idle();

		// plain bytes, tabs, line control, saturation, wrap and scroll
		queue_request(tccw_pkg::ACT_PUT, 8'h41, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_PUT, 8'hFF, 7'd127, 5'd31);
		queue_request(tccw_pkg::ACT_PUT, 8'h00, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_READ_CELL, 8'h00, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_PUT, tccw_pkg::CH_TAB, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_PUT, tccw_pkg::CH_TAB, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_PUT, tccw_pkg::CH_CR, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_PUT, tccw_pkg::CH_LF, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_SET_CURSOR, 8'h00, 7'd127, 5'd31);
		queue_request(tccw_pkg::ACT_READ_CELL, 8'h00, 7'd127, 5'd31);
		queue_request(tccw_pkg::ACT_PUT, 8'h5A, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_READ_CELL, 8'h00, 7'd79, 5'd23);
		queue_request(tccw_pkg::ACT_SET_CURSOR, 8'h00, 7'd78, 5'd24);
		queue_request(tccw_pkg::ACT_PUT, tccw_pkg::CH_TAB, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_SET_CURSOR, 8'h00, 7'd0, 5'd24);
		queue_request(tccw_pkg::ACT_PUT, tccw_pkg::CH_LF, 7'd0, 5'd0);
		wait_idle();

		write_register(tccw_pkg::REG_BLANK_COLOR, 8'hFF);
		write_register(8'hFF, 8'h00);
		queue_request(tccw_pkg::ACT_CLEAR, 8'hAA, 7'd85, 5'd21);
		queue_request(tccw_pkg::ACT_READ_CELL, 8'h00, 7'd10, 5'd5);
		queue_request(tccw_pkg::ACT_SET_CURSOR, 8'h00, 7'd2, 5'd24);
		queue_request(tccw_pkg::ACT_PUT, 8'h71, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_READ_CELL, 8'h00, 7'd2, 5'd24);
		wait_idle();

		// output disabled: no echo, no change
		write_register(tccw_pkg::REG_OUTPUT_ENABLE, 8'h00);
		queue_request(tccw_pkg::ACT_PUT, 8'h78, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_PUT, tccw_pkg::CH_TAB, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_READ_CELL, 8'h00, 7'd3, 5'd24);
		wait_idle();

		write_register(tccw_pkg::REG_OUTPUT_ENABLE, 8'h01);
		write_register(tccw_pkg::REG_BLANK_COLOR, 8'h00);
		queue_request(tccw_pkg::ACT_PUT, tccw_pkg::CH_LF, 7'd0, 5'd0);
		queue_request(tccw_pkg::ACT_READ_CELL, 8'h00, 7'd0, 5'd24);
		queue_request(tccw_pkg::ACT_READ_CELL, 8'h00, 7'd2, 5'd23);
		wait_idle();

		// random phases, each drained before the next setting
		for (int ph = 0; ph < 6; ph++) begin
			write_register(tccw_pkg::REG_OUTPUT_ENABLE, (ph == 3) ? 8'h00 : 8'h01);
			write_register(tccw_pkg::REG_BLANK_COLOR,
				(ph == 5) ? 8'hFF : 8'($urandom_range(0, 255)));
			for (int i = 0; i < 25; i++)
				queue_random_request();
			wait_idle();
		end

		repeat (TAIL) @(negedge clk);
		if (errors == 0)
			$display("PASS text_console_char_writer_top");
		else
			$display("FAIL text_console_char_writer_top");
		$finish;
	end

endmodule

### text_console_char_writer_top.f
+incdir+src
src/tccw_pkg.sv
src/tccw_ctrl.sv
src/tccw_dp.sv
src/text_console_char_writer_top.sv
verif/testbench.sv
